// ===== hdl/rrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and codes of the rotated rectangle row span pipeline.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int COORD_W = 16;
    localparam int ROW_W   = 11;
    localparam int COLOR_W = 24;
    localparam int CFG_W   = 12;

    // order of the selected corners
    localparam int SEL_HI = 0;
    localparam int SEL_LO = 1;
    localparam int SEL_LE = 2;
    localparam int SEL_RI = 3;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_COVERED = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DEGEN   = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [ROW_W-1:0]   span_start;
        logic [ROW_W-1:0]   span_end;
        logic [COLOR_W-1:0] color;
        logic               rot;
    } t_side;

endpackage

// ===== hdl/rrs_corner_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_corner_sel
// Picks top, bottom, left and right corners; ties go to the lower index.
// ----------------------------------------------------------------------------
module rrs_corner_sel (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [rrs_pkg::COORD_W-1:0]   i_x [4],
    input  logic signed [rrs_pkg::COORD_W-1:0]   i_y [4],
    input  logic        [rrs_pkg::ROW_W-1:0]     i_row,
    input  logic        [rrs_pkg::COLOR_W-1:0]   i_color,
    output logic signed [rrs_pkg::COORD_W-1:0]   o_cx [4],
    output logic signed [rrs_pkg::COORD_W-1:0]   o_cy [4],
    output logic        [rrs_pkg::ROW_W-1:0]     o_row,
    output logic        [rrs_pkg::COLOR_W-1:0]   o_color
);

    logic [1:0] hi, lo, le, ri;

    always_comb begin
        hi = 2'd0;
        lo = 2'd0;
        le = 2'd0;
        ri = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if (i_y[hi] > i_y[i]) hi = 2'(i);
            if (i_y[lo] < i_y[i]) lo = 2'(i);
            if (i_x[le] > i_x[i]) le = 2'(i);
            if (i_x[ri] < i_x[i]) ri = 2'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cx[rrs_pkg::SEL_HI] <= i_x[hi];
            o_cy[rrs_pkg::SEL_HI] <= i_y[hi];
            o_cx[rrs_pkg::SEL_LO] <= i_x[lo];
            o_cy[rrs_pkg::SEL_LO] <= i_y[lo];
            o_cx[rrs_pkg::SEL_LE] <= i_x[le];
            o_cy[rrs_pkg::SEL_LE] <= i_y[le];
            o_cx[rrs_pkg::SEL_RI] <= i_x[ri];
            o_cy[rrs_pkg::SEL_RI] <= i_y[ri];
            o_row                 <= i_row;
            o_color               <= i_color;
        end
    end

endmodule

// ===== hdl/rrs_edge_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_edge_setup
// Axis-aligned span, rotated row range and edge terms for both sides.
// ----------------------------------------------------------------------------
module rrs_edge_setup #(
    parameter int FRAC_BITS = 4,
    parameter int DMW       = 12,
    parameter int TW        = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [rrs_pkg::COORD_W-1:0]   i_cx [4],
    input  logic signed [rrs_pkg::COORD_W-1:0]   i_cy [4],
    input  logic        [rrs_pkg::ROW_W-1:0]     i_row,
    input  logic        [rrs_pkg::COLOR_W-1:0]   i_color,
    input  logic        [DMW-1:0]                i_w,
    input  logic        [DMW-1:0]                i_h,
    output rrs_pkg::t_side                       o_side,
    output logic signed [rrs_pkg::COORD_W-1:0]   o_xa [2],
    output logic signed [16:0]                   o_dx [2],
    output logic signed [16:0]                   o_den [2],
    output logic signed [TW-1:0]                 o_dt [2],
    output logic                                 o_flat [2],
    output logic signed [17:0]                   o_fx [2]
);

    function automatic logic signed [17:0] trunc_px(input logic signed [15:0] v);
        logic signed [17:0] ve;
        logic signed [17:0] bias;
        ve   = 18'(v);
        bias = v[15] ? 18'((1 << FRAC_BITS) - 1) : 18'sd0;
        return (ve + bias) >>> FRAC_BITS;
    endfunction

    logic signed [17:0] ty, by, tle, tri_y, lx, rx, ws, hs, rs18;
    logic signed [17:0] top_c, bot_a, bot_r, l_c, rt_c;
    logic signed [TW-1:0] rs;
    logic [TW-1:0] ru;
    logic axis;
    rrs_pkg::t_side side;
    logic signed [15:0] xa [2], ya [2], xb [2], yb [2];
    logic [1:0] side_idx [2];

    assign side_idx[0] = 2'(rrs_pkg::SEL_LE);
    assign side_idx[1] = 2'(rrs_pkg::SEL_RI);

    always_comb begin
        ty    = trunc_px(i_cy[rrs_pkg::SEL_HI]);
        by    = trunc_px(i_cy[rrs_pkg::SEL_LO]);
        tle   = trunc_px(i_cy[rrs_pkg::SEL_LE]);
        tri_y = trunc_px(i_cy[rrs_pkg::SEL_RI]);
        lx    = trunc_px(i_cx[rrs_pkg::SEL_LE]);
        rx    = trunc_px(i_cx[rrs_pkg::SEL_RI]);
        ws    = $signed(18'(i_w));
        hs    = $signed(18'(i_h));
        rs18  = $signed(18'(i_row));
        axis  = (ty == tle) || (ty == tri_y);
        top_c = (ty < 18'sd0) ? 18'sd0 : ty;
        bot_a = (by < hs) ? by : hs;
        bot_r = (by < hs - 18'sd1) ? by : hs - 18'sd1;
        l_c   = (lx < 18'sd0) ? 18'sd0 : lx;
        rt_c  = (rx > ws) ? ws : rx;

        side.status     = rrs_pkg::ST_EMPTY;
        side.span_start = '0;
        side.span_end   = '0;
        side.color      = i_color;
        side.rot        = 1'b0;
        if (axis) begin
            if (top_c >= bot_a || rt_c <= l_c) begin
                side.status = rrs_pkg::ST_DEGEN;
            end else if (rs18 >= top_c && rs18 < bot_a) begin
                side.status     = rrs_pkg::ST_COVERED;
                side.span_start = l_c[rrs_pkg::ROW_W-1:0];
                side.span_end   = 11'(rt_c - 18'sd1);
            end
        end else begin
            if (top_c > bot_r) begin
                side.status = rrs_pkg::ST_DEGEN;
            end else if (rs18 >= top_c && rs18 <= bot_r) begin
                side.rot = 1'b1;
            end
        end

        ru = TW'(i_row) << FRAC_BITS;
        rs = $signed(ru);
        for (int k = 0; k < 2; k++) begin
            if (rs < TW'(i_cy[side_idx[k]])) begin
                xa[k] = i_cx[rrs_pkg::SEL_HI];
                ya[k] = i_cy[rrs_pkg::SEL_HI];
                xb[k] = i_cx[side_idx[k]];
                yb[k] = i_cy[side_idx[k]];
            end else begin
                xa[k] = i_cx[side_idx[k]];
                ya[k] = i_cy[side_idx[k]];
                xb[k] = i_cx[rrs_pkg::SEL_LO];
                yb[k] = i_cy[rrs_pkg::SEL_LO];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= side;
            for (int k = 0; k < 2; k++) begin
                o_xa[k]   <= xa[k];
                o_dx[k]   <= 17'(xb[k]) - 17'(xa[k]);
                o_den[k]  <= 17'(yb[k]) - 17'(ya[k]);
                o_flat[k] <= (17'(yb[k]) - 17'(ya[k])) <= 17'sd0;
                o_dt[k]   <= rs - TW'(ya[k]);
                o_fx[k]   <= trunc_px(xa[k]);
            end
        end
    end

endmodule

// ===== hdl/rrs_edge_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_edge_div
// Edge x at a row: products, sum, saturation test, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rrs_edge_div #(
    parameter int FRAC_BITS = 4,
    parameter int QB        = 12,
    parameter int TW        = 18
) (
    input  logic                      i_clk,
    input  logic [QB+2:0]             i_en,
    input  logic signed [15:0]        i_xa,
    input  logic signed [16:0]        i_dx,
    input  logic signed [16:0]        i_den,
    input  logic signed [TW-1:0]      i_dt,
    input  logic                      i_flat,
    input  logic signed [17:0]        i_fx,
    output logic signed [17:0]        o_x
);

    localparam int NW = 17 + TW + 1;
    localparam int MW = NW - 1;
    localparam int VW = 17 + FRAC_BITS;
    localparam int CW = (MW > VW + QB) ? MW : VW + QB;

    logic signed [32:0]     r_p1;
    logic signed [16+TW:0]  r_p2;
    logic signed [16:0]     r3_den;
    logic                   r3_flat;
    logic signed [17:0]     r3_fx;

    logic [MW-1:0]          r4_mag;
    logic [VW-1:0]          r4_div;
    logic                   r4_neg, r4_flat;
    logic signed [17:0]     r4_fx;

    logic signed [NW-1:0]   n_num;

    logic [CW-1:0]          r_rem [0:QB-1];
    logic [VW-1:0]          r_dv  [0:QB-1];
    logic [QB-1:0]          r_q   [1:QB];
    logic                   r_neg [0:QB];
    logic                   r_sat [0:QB];
    logic                   r_flt [0:QB];
    logic signed [17:0]     r_fx  [0:QB];

    assign n_num = NW'(r_p1) + NW'(r_p2);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p1    <= 33'(i_xa) * 33'(i_den);
            r_p2    <= (17+TW)'(i_dx) * (17+TW)'(i_dt);
            r3_den  <= i_den;
            r3_flat <= i_flat;
            r3_fx   <= i_fx;
        end
        if (i_en[1]) begin
            r4_neg  <= n_num[NW-1];
            r4_mag  <= n_num[NW-1] ? MW'(-n_num) : MW'(n_num);
            r4_div  <= VW'($unsigned(r3_den)) << FRAC_BITS;
            r4_flat <= r3_flat;
            r4_fx   <= r3_fx;
        end
        if (i_en[2]) begin
            r_rem[0] <= CW'(r4_mag);
            r_dv[0]  <= r4_div;
            r_sat[0] <= CW'(r4_mag) >= (CW'(r4_div) << QB);
            r_neg[0] <= r4_neg;
            r_flt[0] <= r4_flat;
            r_fx[0]  <= r4_fx;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [CW-1:0] dsh;
        logic          ge;
        assign dsh = CW'(r_dv[j-1]) << (QB - j);
        assign ge  = r_rem[j-1] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en[2+j]) begin
                r_neg[j] <= r_neg[j-1];
                r_sat[j] <= r_sat[j-1];
                r_flt[j] <= r_flt[j-1];
                r_fx[j]  <= r_fx[j-1];
            end
        end
        if (j < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[2+j]) begin
                    r_rem[j] <= ge ? r_rem[j-1] - dsh : r_rem[j-1];
                    r_dv[j]  <= r_dv[j-1];
                end
            end
        end
        if (j == 1) begin : g_q0
            always_ff @(posedge i_clk) begin
                if (i_en[2+j]) r_q[j] <= QB'(ge);
            end
        end else begin : g_qn
            always_ff @(posedge i_clk) begin
                if (i_en[2+j]) r_q[j] <= {r_q[j-1][QB-2:0], ge};
            end
        end
    end

    logic signed [17:0] mag_o;

    always_comb begin
        mag_o = r_sat[QB] ? 18'sd1 <<< QB : $signed(18'(r_q[QB]));
        if (r_flt[QB]) o_x = r_fx[QB];
        else           o_x = r_neg[QB] ? -mag_o : mag_o;
    end

endmodule

// ===== hdl/rotated_rect_row_span.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rect_row_span
// Covered column span of one image row for a rotated rectangle.
//
// channel  dir  handshake              payload
// s        in   i_s_tvalid/o_s_tready  corners, row, color
// m        out  o_m_tvalid/i_m_tready  status, start, end, color
// cfg      in   i_cfg_wr_en            image width / height
//
// One word per cycle while the output is not stalled; the restoring divider
// yields one quotient bit per stage.
// Reset clears all valid bits and loads width 640, height 480.
// A stall holds the output word; bubbles ahead of it still close up.
// ----------------------------------------------------------------------------
module rotated_rect_row_span #(
    parameter int MAX_DIM   = 2048,
    parameter int FRAC_BITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // x0, y0, x1, y1, x2, y2, x3, y3, row_index, fill_color, pad
    input  logic [167:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // span_status, span_start, span_end, span_color
    output logic [47:0]   o_m_tdata,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_index,
    input  logic [11:0]   i_cfg_wdata
);

    localparam int QB  = $clog2(MAX_DIM) + 1;
    localparam int NS  = QB + 7;
    localparam int DMW = $clog2(MAX_DIM) + 1;
    localparam int TW  = ((11 + FRAC_BITS > 16) ? 11 + FRAC_BITS : 16) + 2;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;
    logic [11:0]   r_cfg_w, r_cfg_h;
    logic [DMW-1:0] dim_w, dim_h;
    logic [162:0]  r_in;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) en[k] = !r_v[k] || en[k+1];
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_cfg_w <= 12'd640;
            r_cfg_h <= 12'd480;
        end else begin
            if (en[0]) r_v[0] <= i_s_tvalid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
            if (i_cfg_wr_en && i_cfg_index == rrs_pkg::CFG_IMAGE_WIDTH)  r_cfg_w <= i_cfg_wdata;
            if (i_cfg_wr_en && i_cfg_index == rrs_pkg::CFG_IMAGE_HEIGHT) r_cfg_h <= i_cfg_wdata;
        end
    end

    function automatic logic [DMW-1:0] clamp_dim(input logic [11:0] v);
        if (v == 12'd0) return DMW'(1);
        if (13'(v) > 13'(MAX_DIM)) return DMW'(MAX_DIM);
        return DMW'(v);
    endfunction

    assign dim_w = clamp_dim(r_cfg_w);
    assign dim_h = clamp_dim(r_cfg_h);

    always_ff @(posedge i_clk) begin
        if (en[0]) r_in <= i_s_tdata[162:0];
    end

    logic signed [15:0] in_x [4], in_y [4];
    for (genvar i = 0; i < 4; i++) begin : g_unpack
        assign in_x[i] = $signed(r_in[32*i +: 16]);
        assign in_y[i] = $signed(r_in[32*i+16 +: 16]);
    end

    logic signed [15:0] cx [4], cy [4];
    logic [10:0] s1_row;
    logic [23:0] s1_color;

    rrs_corner_sel u_sel (
        .i_clk   (i_clk),
        .i_en    (en[1]),
        .i_x     (in_x),
        .i_y     (in_y),
        .i_row   (r_in[138:128]),
        .i_color (r_in[162:139]),
        .o_cx    (cx),
        .o_cy    (cy),
        .o_row   (s1_row),
        .o_color (s1_color)
    );

    rrs_pkg::t_side     s2_side;
    logic signed [15:0] e_xa [2];
    logic signed [16:0] e_dx [2], e_den [2];
    logic signed [TW-1:0] e_dt [2];
    logic               e_flat [2];
    logic signed [17:0] e_fx [2];

    rrs_edge_setup #(.FRAC_BITS(FRAC_BITS), .DMW(DMW), .TW(TW)) u_setup (
        .i_clk   (i_clk),
        .i_en    (en[2]),
        .i_cx    (cx),
        .i_cy    (cy),
        .i_row   (s1_row),
        .i_color (s1_color),
        .i_w     (dim_w),
        .i_h     (dim_h),
        .o_side  (s2_side),
        .o_xa    (e_xa),
        .o_dx    (e_dx),
        .o_den   (e_den),
        .o_dt    (e_dt),
        .o_flat  (e_flat),
        .o_fx    (e_fx)
    );

    logic signed [17:0] edge_x [2];
    for (genvar k = 0; k < 2; k++) begin : g_lane
        rrs_edge_div #(.FRAC_BITS(FRAC_BITS), .QB(QB), .TW(TW)) u_div (
            .i_clk  (i_clk),
            .i_en   (en[NS-2:3]),
            .i_xa   (e_xa[k]),
            .i_dx   (e_dx[k]),
            .i_den  (e_den[k]),
            .i_dt   (e_dt[k]),
            .i_flat (e_flat[k]),
            .i_fx   (e_fx[k]),
            .o_x    (edge_x[k])
        );
    end

    rrs_pkg::t_side r_side [0:NS-5];

    always_ff @(posedge i_clk) begin
        if (en[3]) r_side[0] <= s2_side;
        for (int j = 1; j <= NS - 5; j++) begin
            if (en[3+j]) r_side[j] <= r_side[j-1];
        end
    end

    rrs_pkg::t_side     fin;
    logic signed [17:0] s_c, e_c, wm1;

    always_comb begin
        fin = r_side[NS-5];
        wm1 = $signed(18'(dim_w)) - 18'sd1;
        s_c = (edge_x[0] < 18'sd0) ? 18'sd0 : edge_x[0];
        e_c = (edge_x[1] > wm1) ? wm1 : edge_x[1];
        if (fin.rot) begin
            if (s_c <= e_c) begin
                fin.status     = rrs_pkg::ST_COVERED;
                fin.span_start = s_c[10:0];
                fin.span_end   = e_c[10:0];
            end else begin
                fin.status     = rrs_pkg::ST_EMPTY;
                fin.span_start = '0;
                fin.span_end   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            o_m_tdata <= {fin.color, fin.span_end, fin.span_start, fin.status};
        end
    end

endmodule

// ===== hdl/rrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks of the row span output stream.
// ----------------------------------------------------------------------------
module rrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] i_m_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled word changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[1:0] != 2'd3)
        else $error("bad status code");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[1:0] != rrs_pkg::ST_COVERED
            |-> i_m_tdata[23:2] == 22'd0)
        else $error("span not zero for uncovered row");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[1:0] == rrs_pkg::ST_COVERED
            |-> i_m_tdata[12:2] <= i_m_tdata[23:13])
        else $error("span start past end");

endmodule

bind rotated_rect_row_span rrs_checker u_rrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
